FILE: src/osm_pkg.sv
package osm_pkg;

    localparam int VALUE_W   = 32;
    localparam int SUM_W     = 40;
    localparam int CNT_OUT_W = 7;
    localparam int INDEX_W   = 6;
    localparam int REQ_W     = 3;
    localparam int STATUS_W  = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 3'd0,
        REQ_ERASE  = 3'd1,
        REQ_LOWER  = 3'd2,
        REQ_UPPER  = 3'd3,
        REQ_COUNT  = 3'd4,
        REQ_KTH    = 3'd5
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef struct packed {
        logic lt;
        logic le;
    } t_flags;

    typedef struct packed {
        logic sample;
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

FILE: src/osm_cell.sv
module osm_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                                  i_clk,
    input  osm_pkg::t_cell_ctl                    i_ctl,
    input  logic signed [osm_pkg::VALUE_W-1:0]    i_probe,
    input  logic signed [osm_pkg::VALUE_W-1:0]    i_key,
    input  logic [CW-1:0]                         i_occ,
    input  logic [osm_pkg::INDEX_W-1:0]           i_index,
    input  logic                                  i_left_lt,
    input  logic signed [osm_pkg::VALUE_W-1:0]    i_left_value,
    input  osm_pkg::t_flags                       i_right_flags,
    input  logic signed [osm_pkg::VALUE_W-1:0]    i_right_value,
    output logic signed [osm_pkg::VALUE_W-1:0]    o_value,
    output osm_pkg::t_flags                       o_flags,
    output logic [CW-1:0]                         o_lt_rank,
    output logic [CW-1:0]                         o_le_rank,
    output logic signed [osm_pkg::VALUE_W-1:0]    o_pick
);

    localparam logic [CW-1:0] POS  = CW'(IDX);
    localparam logic [CW-1:0] RANK = CW'(IDX + 1);
    localparam logic [CW+osm_pkg::INDEX_W-1:0] POS_K = (CW + osm_pkg::INDEX_W)'(IDX);

    logic signed [osm_pkg::VALUE_W-1:0] r_value;
    osm_pkg::t_flags                    r_flags;
    logic                               live;
    logic                               hit;

    assign live = POS < i_occ;
    assign hit  = {{CW{1'b0}}, i_index} == POS_K;

    always_ff @(posedge i_clk) begin
        if (i_ctl.sample) begin
            r_flags.lt <= live && (r_value < i_probe);
            r_flags.le <= live && (r_value <= i_probe);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && !r_flags.lt) begin
            r_value <= i_left_lt ? i_key : i_left_value;
        end else if (i_ctl.del && !r_flags.lt) begin
            r_value <= i_right_value;
        end
    end

    assign o_value   = r_value;
    assign o_flags   = r_flags;
    assign o_lt_rank = (r_flags.lt && !i_right_flags.lt) ? RANK : '0;
    assign o_le_rank = (r_flags.le && !i_right_flags.le) ? RANK : '0;
    assign o_pick    = hit ? r_value : '0;

endmodule

FILE: src/order_statistic_multiset_unit.sv
// A transaction accepted in idle moves to the execute state; its result is registered as it leaves execute.
// Input is stalled in execute, so transactions do not overlap; each makes a compare-then-shift pass
// through the row of cells, and an output stall holds the execute state.
// A write to the identity register blocks input while the sum reloads.
// Reset (synchronous, active low) empties the store and clears size, sum and identity.
module order_statistic_multiset_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic signed [osm_pkg::VALUE_W-1:0]   i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [osm_pkg::REQ_W-1:0]            i_req_type,
    input  logic signed [osm_pkg::VALUE_W-1:0]   i_value_in,
    input  logic [osm_pkg::INDEX_W-1:0]          i_index_in,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [osm_pkg::STATUS_W-1:0]         o_status,
    output logic [osm_pkg::CNT_OUT_W-1:0]        o_rank_out,
    output logic signed [osm_pkg::VALUE_W-1:0]   o_value_out,
    output logic [osm_pkg::CNT_OUT_W-1:0]        o_size_out,
    output logic signed [osm_pkg::SUM_W-1:0]     o_sum_out
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = osm_pkg::VALUE_W;
    localparam int SW = osm_pkg::SUM_W;
    localparam int OW = osm_pkg::CNT_OUT_W;
    localparam int KW = osm_pkg::INDEX_W;
    localparam int PW = CW + VW + 2;
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0]           r_occ, n_occ;
    logic signed [SW-1:0]    r_sum, n_sum;
    logic signed [SW-1:0]    r_total, n_total;
    logic signed [VW-1:0]    r_identity;
    logic                    r_cfg_pend;
    logic signed [SW-1:0]    r_prod;
    logic signed [SW-1:0]    r_sum_ins, r_sum_del, r_tot_ins, r_tot_del;
    logic [osm_pkg::REQ_W-1:0] r_req;
    logic signed [VW-1:0]    r_key;
    logic [KW-1:0]           r_index;
    logic                    r_out_valid;

    osm_pkg::t_status        r_status, n_status;
    logic [OW-1:0]           r_rank, r_size;
    logic signed [VW-1:0]    r_value_out, n_pick;
    logic signed [SW-1:0]    r_sum_out;
    logic [CW-1:0]           n_rank;

    logic                    accept, done, full, found;
    logic                    ins_ok, del_ok;
    osm_pkg::t_cell_ctl      ctl;

    logic signed [VW-1:0]    cell_value [CAPACITY];
    osm_pkg::t_flags         cell_flags [CAPACITY];
    logic [CW-1:0]           cell_lt_rank [CAPACITY];
    logic [CW-1:0]           cell_le_rank [CAPACITY];
    logic signed [VW-1:0]    cell_pick [CAPACITY];

    logic [CW-1:0]           lt_cnt, le_cnt;
    logic signed [VW-1:0]    pick;

    logic signed [SW-1:0]    v_ext, id_ext;
    logic [CW:0]             occ_plus1;
    logic signed [PW-1:0]    prod_full;
    logic signed [PW+SW-1:0] prod_wide;
    logic [CW+OW-1:0]        rank_wide, size_wide;
    logic [CW+KW-1:0]        k_ext, occ_ext;

    assign accept = i_valid && !o_stall;
    assign done   = (r_state == S_EXEC) && (!r_out_valid || !i_stall);
    assign full   = r_occ >= FULL_COUNT;

    assign o_stall = !((r_state == S_IDLE) && !r_cfg_pend);

    assign ctl = {accept, done && ins_ok, done && del_ok};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                 left_lt;
        logic signed [VW-1:0] left_value, right_value;
        osm_pkg::t_flags      right_flags;

        if (g == 0) begin : g_first
            assign left_lt    = 1'b1;
            assign left_value = '0;
        end else begin : g_mid_l
            assign left_lt    = cell_flags[g-1].lt;
            assign left_value = cell_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_flags = '0;
            assign right_value = '0;
        end else begin : g_mid_r
            assign right_flags = cell_flags[g+1];
            assign right_value = cell_value[g+1];
        end

        osm_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_probe       (i_value_in),
            .i_key         (r_key),
            .i_occ         (r_occ),
            .i_index       (r_index),
            .i_left_lt     (left_lt),
            .i_left_value  (left_value),
            .i_right_flags (right_flags),
            .i_right_value (right_value),
            .o_value       (cell_value[g]),
            .o_flags       (cell_flags[g]),
            .o_lt_rank     (cell_lt_rank[g]),
            .o_le_rank     (cell_le_rank[g]),
            .o_pick        (cell_pick[g])
        );
    end

    always_comb begin
        lt_cnt = '0;
        le_cnt = '0;
        pick   = '0;
        found  = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            lt_cnt = lt_cnt | cell_lt_rank[i];
            le_cnt = le_cnt | cell_le_rank[i];
            pick   = pick | cell_pick[i];
            found  = found | (cell_flags[i].le & ~cell_flags[i].lt);
        end
    end

    assign k_ext   = (CW + KW)'(r_index);
    assign occ_ext = (CW + KW)'(r_occ);

    always_comb begin
        n_status = osm_pkg::ST_OK;
        n_rank   = '0;
        n_pick   = '0;
        n_occ    = r_occ;
        n_sum    = r_sum;
        n_total  = r_total;
        ins_ok   = 1'b0;
        del_ok   = 1'b0;
        case (r_req)
            osm_pkg::REQ_INSERT: begin
                if (full) begin
                    n_status = osm_pkg::ST_FULL;
                end else begin
                    ins_ok  = 1'b1;
                    n_occ   = r_occ + CW'(1);
                    n_sum   = r_sum_ins;
                    n_total = r_tot_ins;
                end
            end
            osm_pkg::REQ_ERASE: begin
                if (!found) begin
                    n_status = osm_pkg::ST_NOT_FOUND;
                end else begin
                    del_ok  = 1'b1;
                    n_occ   = r_occ - CW'(1);
                    n_sum   = r_sum_del;
                    n_total = r_tot_del;
                end
            end
            osm_pkg::REQ_LOWER: n_rank = lt_cnt;
            osm_pkg::REQ_UPPER: n_rank = le_cnt;
            osm_pkg::REQ_COUNT: n_rank = le_cnt - lt_cnt;
            osm_pkg::REQ_KTH: begin
                if (k_ext >= occ_ext) begin
                    n_status = osm_pkg::ST_RANGE;
                end else begin
                    n_pick = pick;
                end
            end
            default: begin
            end
        endcase
    end

    assign rank_wide = (CW + OW)'(n_rank);
    assign size_wide = (CW + OW)'(n_occ);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_EXEC;
            S_EXEC:  if (done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign v_ext     = SW'(i_value_in);
    assign id_ext    = SW'(r_identity);
    assign occ_plus1 = {1'b0, r_occ} + (CW + 1)'(1);
    assign prod_full = PW'($signed({1'b0, occ_plus1})) * PW'(i_cfg_data);
    assign prod_wide = (PW + SW)'(prod_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_sum       <= '0;
            r_total     <= '0;
            r_identity  <= '0;
            r_cfg_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cfg_pend <= i_cfg_we;
            if (i_cfg_we) begin
                r_identity <= i_cfg_data;
            end
            if (r_cfg_pend) begin
                r_sum <= r_total + r_prod;
            end else if (done) begin
                r_sum <= n_sum;
            end
            if (done) begin
                r_occ   <= n_occ;
                r_total <= n_total;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            r_prod <= prod_wide[SW-1:0];
        end
        if (accept) begin
            r_req     <= i_req_type;
            r_key     <= i_value_in;
            r_index   <= i_index_in;
            r_sum_ins <= r_sum + v_ext + id_ext;
            r_sum_del <= r_sum - v_ext - id_ext;
            r_tot_ins <= r_total + v_ext;
            r_tot_del <= r_total - v_ext;
        end
        if (done) begin
            r_status    <= n_status;
            r_rank      <= rank_wide[OW-1:0];
            r_value_out <= n_pick;
            r_size      <= size_wide[OW-1:0];
            r_sum_out   <= n_sum;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_rank_out  = r_rank;
    assign o_value_out = r_value_out;
    assign o_size_out  = r_size;
    assign o_sum_out   = r_sum_out;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= FULL_COUNT)
        else $error("occupancy beyond capacity");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted transaction did not start");

    a_exec_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> o_stall)
        else $error("input open while a transaction is in flight");

    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && ins_ok) |=> (r_occ == $past(r_occ) + CW'(1)))
        else $error("insert did not grow the store");

    a_full_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && n_status == osm_pkg::ST_FULL) |-> (r_occ == FULL_COUNT))
        else $error("full flagged below capacity");

endmodule
